### rtl/slt_pkg.sv
// Shared types, constants and lookup functions for the script tokeniser.
`default_nettype none
package slt_pkg;

  localparam int unsigned MaxScriptBytes = 1048576;
  localparam int unsigned KindW  = 6;
  localparam int unsigned StartW = 20;
  localparam int unsigned LenW   = 21;
  localparam int unsigned WordCap = 9;
  localparam int unsigned MaxRes  = 5;

  localparam logic [KindW-1:0] KEnd     = 6'd0;
  localparam logic [KindW-1:0] KSpace   = 6'd1;
  localparam logic [KindW-1:0] KIdent   = 6'd2;
  localparam logic [KindW-1:0] KNumber  = 6'd3;
  localparam logic [KindW-1:0] KSymbol0 = 6'd4;
  localparam logic [KindW-1:0] KWord0   = 6'd29;

  localparam logic [1:0] SegNone  = 2'd0;
  localparam logic [1:0] SegIdent = 2'd1;
  localparam logic [1:0] SegNum   = 2'd2;

  localparam logic [1:0] CmNone   = 2'd0;
  localparam logic [1:0] CmLine   = 2'd1;
  localparam logic [1:0] CmBlock  = 2'd2;
  localparam logic [1:0] CmOpener = 2'd3;

  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
  } token_t;

  // input word: one script byte
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_word_t;

  // output word: one token
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic              last;
  } out_word_t;

  typedef logic [WordCap*8-1:0] wordbuf_t;

  function automatic logic is_space(input logic [7:0] x);
    return x == 8'h0A || x == 8'h09 || x == 8'h0D || x == 8'h20;
  endfunction

  // symbol lookup: returns valid flag and kind
  function automatic logic [KindW:0] symbol_kind(input logic [7:0] x);
    logic [4:0] i;
    logic       hit;
    hit = 1'b1;
    i = 5'd0;
    case (x)
      8'h2B: i = 5'd0;  8'h2D: i = 5'd1;  8'h2A: i = 5'd2;  8'h2F: i = 5'd3;
      8'h21: i = 5'd4;  8'h26: i = 5'd5;  8'h7C: i = 5'd6;  8'h3D: i = 5'd7;
      8'h28: i = 5'd8;  8'h29: i = 5'd9;  8'h3C: i = 5'd10; 8'h3E: i = 5'd11;
      8'h7B: i = 5'd12; 8'h7D: i = 5'd13; 8'h2E: i = 5'd14; 8'h5E: i = 5'd15;
      8'h3B: i = 5'd16; 8'h27: i = 5'd17; 8'h22: i = 5'd18; 8'h5B: i = 5'd19;
      8'h5D: i = 5'd20; 8'h2C: i = 5'd21; 8'h3A: i = 5'd22; 8'h5C: i = 5'd23;
      8'h40: i = 5'd24;
      default: hit = 1'b0;
    endcase
    return {hit, KSymbol0 + {1'b0, i}};
  endfunction

  // word text packed with first byte in the low byte
  function automatic wordbuf_t word_text(input logic [4:0] w);
    case (w)
      5'd0:  return wordbuf_t'("fi");
      5'd1:  return wordbuf_t'("od");
      5'd2:  return wordbuf_t'("elihw");
      5'd3:  return wordbuf_t'("rof");
      5'd4:  return wordbuf_t'("nruter");
      5'd5:  return wordbuf_t'("esac");
      5'd6:  return wordbuf_t'("kaerb");
      5'd7:  return wordbuf_t'("noitcnuf");
      5'd8:  return wordbuf_t'("tluafed");
      5'd9:  return wordbuf_t'("esle");
      5'd10: return wordbuf_t'("eurt");
      5'd11: return wordbuf_t'("eslaf");
      5'd12: return wordbuf_t'("naeloob");
      5'd13: return wordbuf_t'("llun");
      5'd14: return wordbuf_t'("tel");
      5'd15: return wordbuf_t'("si");
      5'd16: return wordbuf_t'("taolf");
      5'd17: return wordbuf_t'("tni");
      5'd18: return wordbuf_t'("yarra");
      5'd19: return wordbuf_t'("gnirts");
      5'd20: return wordbuf_t'("epyt");
      5'd21: return wordbuf_t'("sa");
      5'd22: return wordbuf_t'("enituoroc");
      5'd23: return wordbuf_t'("tcejbo");
      5'd24: return wordbuf_t'("atadresu");
      5'd25: return wordbuf_t'("rav");
      default: return '0;
    endcase
  endfunction

  function automatic logic [3:0] word_len(input logic [4:0] w);
    case (w)
      5'd0, 5'd1, 5'd15, 5'd21: return 4'd2;
      5'd3, 5'd14, 5'd17, 5'd25: return 4'd3;
      5'd5, 5'd9, 5'd10, 5'd13, 5'd20: return 4'd4;
      5'd2, 5'd6, 5'd11, 5'd16, 5'd18: return 4'd5;
      5'd4, 5'd19, 5'd23: return 4'd6;
      5'd8, 5'd12: return 4'd7;
      5'd7, 5'd24: return 4'd8;
      5'd22: return 4'd9;
      default: return 4'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/slt_stream_if.sv
// Valid/ready channel carrying one word of payload type.
`default_nettype none
interface slt_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/script_lexer_tokenizer_top.sv
// Top level of the streaming script tokeniser.
`default_nettype none
// One input word is one script byte; it yields zero to five tokens. A byte is taken
// into the input register. Once the result buffer is empty or is sending its last
// token, the byte's tokens are worked out in one pass and parked in the five-entry
// result buffer, which drains one token per cycle while the output is ready. A new
// byte is worked on only after the previous byte's tokens have all left or are leaving.
// The byte is held back one step so a slash can see what follows it.
module script_lexer_tokenizer_top
  import slt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  slt_stream_if.sink   in_i,
  slt_stream_if.source out_o
);

  // input register
  logic       iv_q;
  logic [7:0] ib_q;
  logic       il_q;

  logic [7:0]        held_byte_q, held_byte_d;
  logic              held_valid_q, held_valid_d;
  logic [LenW-1:0]   offset_q, offset_d;
  wordbuf_t          wbuf_q, wbuf_d;
  logic [1:0]        seg_kind_q, seg_kind_d;
  logic [StartW-1:0] seg_start_q, seg_start_d;
  logic [LenW-1:0]   seg_len_q, seg_len_d;
  logic              cand_q, cand_d;
  logic              sp_act_q, sp_act_d;
  logic [LenW-1:0]   sp_start_q, sp_start_d;
  logic              in_str_q, in_str_d;
  logic [1:0]        cmode_q, cmode_d;
  logic              star_q, star_d;

  token_t [MaxRes-1:0] tok, buf_q;
  logic [2:0]          ntok, cnt_q, idx_q;

  slt_step u_step (
    .byte_i(ib_q), .last_i(il_q),
    .held_byte_i(held_byte_q), .held_valid_i(held_valid_q), .offset_i(offset_q),
    .wbuf_i(wbuf_q), .seg_kind_i(seg_kind_q), .seg_start_i(seg_start_q),
    .seg_len_i(seg_len_q), .cand_i(cand_q), .sp_act_i(sp_act_q),
    .sp_start_i(sp_start_q), .in_str_i(in_str_q), .cmode_i(cmode_q), .star_i(star_q),
    .held_byte_o(held_byte_d), .held_valid_o(held_valid_d), .offset_o(offset_d),
    .wbuf_o(wbuf_d), .seg_kind_o(seg_kind_d), .seg_start_o(seg_start_d),
    .seg_len_o(seg_len_d), .cand_o(cand_d), .sp_act_o(sp_act_d),
    .sp_start_o(sp_start_d), .in_str_o(in_str_d), .cmode_o(cmode_d), .star_o(star_d),
    .tok_o(tok), .ntok_o(ntok)
  );

  logic out_fire, buf_done, proc;
  assign out_fire = out_o.valid && out_o.ready;
  // buffer empties this cycle (or is empty)
  assign buf_done = (cnt_q == '0) || (out_fire && idx_q == cnt_q - 3'd1);
  assign proc     = iv_q && buf_done;
  assign in_i.ready = !iv_q || proc;

  assign out_o.valid = cnt_q != '0;
  always_comb begin
    out_o.data.kind  = buf_q[idx_q].kind;
    out_o.data.start = buf_q[idx_q].start;
    out_o.data.len   = buf_q[idx_q].len;
    out_o.data.last  = idx_q == cnt_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      held_byte_q <= '0; held_valid_q <= 1'b0; offset_q <= '0;
      seg_kind_q <= SegNone; seg_start_q <= '0; seg_len_q <= '0; cand_q <= 1'b1;
      sp_act_q <= 1'b0; sp_start_q <= '0; in_str_q <= 1'b0;
      cmode_q <= CmNone; star_q <= 1'b0;
      cnt_q <= '0; idx_q <= '0;
    end else begin
      if (in_i.ready) iv_q <= in_i.valid;
      if (proc) begin
        held_byte_q <= held_byte_d; held_valid_q <= held_valid_d; offset_q <= offset_d;
        seg_kind_q <= seg_kind_d; seg_start_q <= seg_start_d; seg_len_q <= seg_len_d;
        cand_q <= cand_d; sp_act_q <= sp_act_d; sp_start_q <= sp_start_d;
        in_str_q <= in_str_d; cmode_q <= cmode_d; star_q <= star_d;
        cnt_q <= ntok; idx_q <= '0;
      end else if (out_fire) begin
        if (idx_q == cnt_q - 3'd1) begin
          cnt_q <= '0; idx_q <= '0;
        end else idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ib_q <= in_i.data.byte_value;
      il_q <= in_i.data.last_byte;
    end
    if (proc) begin
      wbuf_q <= wbuf_d;
      buf_q  <= tok;
    end
  end

endmodule
`default_nettype wire

### rtl/slt_step.sv
// Combinational step: held byte plus incoming byte to next state and up to five tokens.
`default_nettype none
module slt_step
  import slt_pkg::*;
(
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  input  wire logic [7:0]       held_byte_i,
  input  wire logic             held_valid_i,
  input  wire logic [LenW-1:0]  offset_i,
  input  wire wordbuf_t         wbuf_i,
  input  wire logic [1:0]       seg_kind_i,
  input  wire logic [StartW-1:0] seg_start_i,
  input  wire logic [LenW-1:0]  seg_len_i,
  input  wire logic             cand_i,
  input  wire logic             sp_act_i,
  input  wire logic [LenW-1:0]  sp_start_i,
  input  wire logic             in_str_i,
  input  wire logic [1:0]       cmode_i,
  input  wire logic             star_i,
  output logic [7:0]            held_byte_o,
  output logic                  held_valid_o,
  output logic [LenW-1:0]       offset_o,
  output wordbuf_t              wbuf_o,
  output logic [1:0]            seg_kind_o,
  output logic [StartW-1:0]     seg_start_o,
  output logic [LenW-1:0]       seg_len_o,
  output logic                  cand_o,
  output logic                  sp_act_o,
  output logic [LenW-1:0]       sp_start_o,
  output logic                  in_str_o,
  output logic [1:0]            cmode_o,
  output logic                  star_o,
  output token_t [MaxRes-1:0]   tok_o,
  output logic [2:0]            ntok_o
);

  localparam logic [LenW-1:0] SatMax = LenW'(MaxScriptBytes);

  typedef struct packed {
    logic [LenW-1:0]   offset;
    wordbuf_t          wbuf;
    logic [1:0]        seg_kind;
    logic [StartW-1:0] seg_start;
    logic [LenW-1:0]   seg_len;
    logic              cand;
    logic              sp_act;
    logic [LenW-1:0]   sp_start;
    logic              in_str;
    logic [1:0]        cmode;
    logic              star;
  } st_t;

  function automatic logic [LenW-1:0] sat_inc(input logic [LenW-1:0] v);
    return (v < SatMax) ? v + 1'b1 : SatMax;
  endfunction

  function automatic logic [KindW:0] match_word(input wordbuf_t b,
                                                input logic [LenW-1:0] len);
    logic [KindW:0] r;
    wordbuf_t       m;
    r = '0;
    for (int w = 25; w >= 0; w--) begin
      m = '0;
      for (int i = 0; i < WordCap; i++)
        if (4'(i) < word_len(5'(w))) m[i*8 +: 8] = 8'hFF;
      if (len == LenW'(word_len(5'(w))) && ((b ^ word_text(5'(w))) & m) == '0)
        r = {1'b1, KWord0 + 6'(w)};
    end
    return r;
  endfunction

  // emit into slot list
  function automatic void push(inout token_t [MaxRes-1:0] t, inout logic [2:0] n,
                               input logic [KindW-1:0] k, input logic [StartW-1:0] s,
                               input logic [LenW-1:0] l);
    if (n < 3'(MaxRes)) begin
      t[n] = '{kind: k, start: s, len: l};
      n = n + 3'd1;
    end
  endfunction

  function automatic void flush(inout st_t s, inout token_t [MaxRes-1:0] t,
                                inout logic [2:0] n);
    logic [KindW:0] wm;
    wm = '0;
    if (s.seg_kind != SegNone) begin
      if (s.cand && s.seg_kind == SegIdent && s.seg_len <= LenW'(WordCap))
        wm = match_word(s.wbuf, s.seg_len);
      if (wm[KindW]) push(t, n, wm[KindW-1:0], s.seg_start, s.seg_len);
      else push(t, n, KindW'(s.seg_kind) + 6'd1, s.seg_start, s.seg_len);
    end
    s.seg_kind = SegNone;
    s.seg_len  = '0;
    s.cand     = 1'b1;
  endfunction

  function automatic void take(inout st_t s, inout token_t [MaxRes-1:0] t,
                               inout logic [2:0] n, input logic [7:0] x,
                               input logic has_next, input logic [7:0] nx);
    logic [LenW-1:0] pos;
    logic [KindW:0]  sk;
    logic [1:0]      cls;
    pos = s.offset;
    s.offset = sat_inc(s.offset);
    sk = symbol_kind(x);
    cls = (x >= 8'h30 && x <= 8'h39) ? SegNum : SegIdent;
    if (s.cmode == CmLine) begin
      if (x == ChNl) s.cmode = CmNone;
    end else if (s.cmode == CmOpener) begin
      s.cmode = CmBlock;
      s.star  = 1'b0;
    end else if (s.cmode == CmBlock) begin
      if (s.star && x == ChSlash) begin
        s.cmode = CmNone;
        s.star  = 1'b0;
      end else s.star = (x == ChStar);
    end else if (is_space(x)) begin
      flush(s, t, n);
      if (!s.sp_act) begin
        s.sp_act   = 1'b1;
        s.sp_start = pos;
      end
    end else begin
      if (s.sp_act) begin
        push(t, n, KSpace, s.sp_start[StartW-1:0], pos - s.sp_start);
        s.sp_act = 1'b0;
      end
      if (x == ChSlash && has_next && (nx == ChSlash || nx == ChStar) && !s.in_str) begin
        flush(s, t, n);
        s.cmode = (nx == ChSlash) ? CmLine : CmOpener;
      end else if (sk[KindW]) begin
        flush(s, t, n);
        push(t, n, sk[KindW-1:0], pos[StartW-1:0], LenW'(1));
        if (x == ChQuote) s.in_str = !s.in_str;
      end else begin
        if (s.seg_kind != SegNone && s.seg_kind != cls) begin
          push(t, n, KindW'(s.seg_kind) + 6'd1, s.seg_start, s.seg_len);
          s.seg_kind = SegNone;
          s.cand     = 1'b0;
        end
        if (s.seg_kind == SegNone) begin
          s.seg_kind  = cls;
          s.seg_start = pos[StartW-1:0];
          s.seg_len   = '0;
        end
        if (s.cand) begin
          if (s.seg_len < LenW'(WordCap)) begin
            for (int i = 0; i < WordCap; i++)
              if (s.seg_len[3:0] == 4'(i)) s.wbuf[i*8 +: 8] = x;
          end else s.cand = 1'b0;
        end
        if (cls == SegNum) s.cand = 1'b0;
        s.seg_len = sat_inc(s.seg_len);
      end
    end
  endfunction

  always_comb begin
    st_t              s;
    token_t [MaxRes-1:0] t;
    logic [2:0]       n;
    s = '{offset: offset_i, wbuf: wbuf_i, seg_kind: seg_kind_i, seg_start: seg_start_i,
          seg_len: seg_len_i, cand: cand_i, sp_act: sp_act_i, sp_start: sp_start_i,
          in_str: in_str_i, cmode: cmode_i, star: star_i};
    t = '0;
    n = '0;
    held_byte_o  = byte_i;
    held_valid_o = 1'b1;
    if (held_valid_i) take(s, t, n, held_byte_i, 1'b1, byte_i);
    if (last_i) begin
      take(s, t, n, byte_i, 1'b0, 8'h00);
      flush(s, t, n);
      if (s.sp_act) push(t, n, KSpace, s.sp_start[StartW-1:0], s.offset - s.sp_start);
      push(t, n, KEnd, '0, '0);
      s = '{offset: '0, wbuf: s.wbuf, seg_kind: SegNone, seg_start: '0, seg_len: '0,
            cand: 1'b1, sp_act: 1'b0, sp_start: '0, in_str: 1'b0, cmode: CmNone,
            star: 1'b0};
      held_byte_o  = 8'h00;
      held_valid_o = 1'b0;
    end
    offset_o    = s.offset;
    wbuf_o      = s.wbuf;
    seg_kind_o  = s.seg_kind;
    seg_start_o = s.seg_start;
    seg_len_o   = s.seg_len;
    cand_o      = s.cand;
    sp_act_o    = s.sp_act;
    sp_start_o  = s.sp_start;
    in_str_o    = s.in_str;
    cmode_o     = s.cmode;
    star_o      = s.star;
    tok_o       = t;
    ntok_o      = n;
  end

endmodule
`default_nettype wire
